### sv/rgbhsv_pkg.sv
`default_nettype none

package rgbhsv_pkg;

	localparam int CH_W   = 8;
	localparam int HUE_W  = 9;
	localparam int PCT_W  = 7;

	localparam int NUM_W  = 15;
	localparam int QUO_W  = 7;

	localparam int LATENCY = 3 + QUO_W;

	localparam int DEG_SPAN   = 60;
	localparam int PCT_SCALE  = 100;
	localparam int HUE_WRAP   = 360;
	localparam int HUE_MAX    = 359;
	localparam int BASE_GREEN = 120;
	localparam int BASE_BLUE  = 240;

	localparam logic [1:0] SECT_RED   = 2'd0;
	localparam logic [1:0] SECT_GREEN = 2'd1;
	localparam logic [1:0] SECT_BLUE  = 2'd2;

	typedef struct packed {
		logic [1:0]       sector;
		logic             neg;
		logic             gray;
		logic             dark;
		logic [PCT_W-1:0] val;
	} side_t;

endpackage

`default_nettype wire

### sv/rgbhsv_div.sv
`default_nettype none

module rgbhsv_div #(
	parameter int NUM_W = 15,
	parameter int DEN_W = 8,
	parameter int QUO_W = 7
) (
	input  wire logic             clk,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [QUO_W-1:0] quo
);

	localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

	logic [NUM_W-1:0] rem_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int BIT = QUO_W - 1 - k;

		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [CMP_W-1:0] trial;
		logic [CMP_W-1:0] dsh;
		logic             fit;
		logic [QUO_W-1:0] quo_n;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign trial = CMP_W'(rem_in);
		assign dsh   = CMP_W'(den_in) << BIT;
		assign fit   = trial >= dsh;

		always_comb begin
			quo_n      = quo_in;
			quo_n[BIT] = fit;
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= fit ? NUM_W'(trial - dsh) : rem_in;
			den_s[k] <= den_in;
			quo_s[k] <= quo_n;
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

`default_nettype wire

### sv/rgb_to_hsv_pixel.sv
// a start beat reaches the done strobe through stage 1, stage 2, the divider stages and the done register
// throughput: one pixel per cycle; busy is never raised
// each quotient comes from a seven-stage restoring divider, one bit per stage
// the receiver cannot stall; done is high for exactly one cycle per result
// arst_n clears all valid bits and the done strobe; payload registers are not reset
`default_nettype none

module rgb_to_hsv_pixel (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [rgbhsv_pkg::CH_W-1:0] red,
	input  wire logic [rgbhsv_pkg::CH_W-1:0] green,
	input  wire logic [rgbhsv_pkg::CH_W-1:0] blue,
	output logic                           busy,
	output logic                           done,
	output logic [rgbhsv_pkg::HUE_W-1:0]   hue_deg,
	output logic [rgbhsv_pkg::PCT_W-1:0]   sat_pct,
	output logic [rgbhsv_pkg::PCT_W-1:0]   val_pct
);

	import rgbhsv_pkg::*;

	logic            accept;
	logic [CH_W-1:0] hi;
	logic [CH_W-1:0] lo;
	logic [CH_W-1:0] minu;
	logic [CH_W-1:0] subt;
	logic [1:0]      sector;

	logic            valid_s1;
	logic [1:0]      sector_s1;
	logic            neg_s1;
	logic [CH_W-1:0] diff_s1;
	logic [CH_W-1:0] span_s1;
	logic [CH_W-1:0] hi_s1;

	logic             valid_s2;
	logic [1:0]       sector_s2;
	logic             neg_s2;
	logic             gray_s2;
	logic             dark_s2;
	logic [NUM_W-1:0] hnum_s2;
	logic [NUM_W-1:0] snum_s2;
	logic [CH_W-1:0]  span_s2;
	logic [CH_W-1:0]  hi_s2;
	logic [NUM_W-1:0] vmul_s2;

	logic [NUM_W:0]   vsum;
	side_t            side_in;
	logic             valid_s [QUO_W];
	side_t            side_s  [QUO_W];

	logic [QUO_W-1:0] hue_q;
	logic [QUO_W-1:0] sat_q;
	logic [HUE_W:0]   base;
	logic [HUE_W:0]   hraw;
	logic [HUE_W:0]   hwrap;
	side_t            side_o;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// stage 1: extremes, sector and channel difference
	always_comb begin
		hi = (red > green) ? red : green;
		hi = (hi > blue) ? hi : blue;
		lo = (red < green) ? red : green;
		lo = (lo < blue) ? lo : blue;
		priority if (blue == hi) begin
			sector = SECT_BLUE;
			minu   = red;
			subt   = green;
		end else if (green == hi) begin
			sector = SECT_GREEN;
			minu   = blue;
			subt   = red;
		end else begin
			sector = SECT_RED;
			minu   = green;
			subt   = blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		sector_s1 <= sector;
		neg_s1    <= minu < subt;
		diff_s1   <= (minu < subt) ? subt - minu : minu - subt;
		span_s1   <= hi - lo;
		hi_s1     <= hi;
	end

	// stage 2: scale by constants
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sector_s2 <= sector_s1;
		neg_s2    <= neg_s1;
		gray_s2   <= span_s1 == '0;
		dark_s2   <= hi_s1 == '0;
		hnum_s2   <= NUM_W'(diff_s1 * NUM_W'(DEG_SPAN));
		snum_s2   <= NUM_W'(span_s1 * NUM_W'(PCT_SCALE));
		span_s2   <= span_s1;
		hi_s2     <= hi_s1;
		vmul_s2   <= NUM_W'(hi_s1 * NUM_W'(PCT_SCALE));
	end

	// divide by 255: (x + 1 + (x >> 8)) >> 8
	assign vsum = (NUM_W+1)'(vmul_s2) + (NUM_W+1)'(1) + (NUM_W+1)'(vmul_s2 >> 8);

	always_comb begin
		side_in.sector = sector_s2;
		side_in.neg    = neg_s2;
		side_in.gray   = gray_s2;
		side_in.dark   = dark_s2;
		side_in.val    = PCT_W'(vsum >> 8);
	end

	rgbhsv_div #(
		.NUM_W(NUM_W),
		.DEN_W(CH_W),
		.QUO_W(QUO_W)
	) u_hue_div (
		.clk(clk),
		.num(hnum_s2),
		.den(span_s2),
		.quo(hue_q)
	);

	rgbhsv_div #(
		.NUM_W(NUM_W),
		.DEN_W(CH_W),
		.QUO_W(QUO_W)
	) u_sat_div (
		.clk(clk),
		.num(snum_s2),
		.den(hi_s2),
		.quo(sat_q)
	);

	// side data rides alongside the divider stages
	for (genvar k = 0; k < QUO_W; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= (k == 0) ? valid_s2 : valid_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			side_s[k] <= (k == 0) ? side_in : side_s[(k == 0) ? 0 : k-1];
		end
	end

	// final stage: hue assembly and wrap
	assign side_o = side_s[QUO_W-1];

	always_comb begin
		unique case (side_o.sector)
			SECT_BLUE:  base = (HUE_W+1)'(BASE_BLUE);
			SECT_GREEN: base = (HUE_W+1)'(BASE_GREEN);
			default:    base = '0;
		endcase
		hraw  = side_o.neg ? base - (HUE_W+1)'(hue_q) : base + (HUE_W+1)'(hue_q);
		hwrap = hraw[HUE_W] ? hraw + (HUE_W+1)'(HUE_WRAP) : hraw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s[QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		hue_deg <= side_o.gray ? '0 : HUE_W'(hwrap);
		sat_pct <= side_o.dark ? '0 : PCT_W'(sat_q);
		val_pct <= side_o.val;
	end

endmodule

`default_nettype wire

### sv/rgb_to_hsv_pixel_chk.sv
`default_nettype none

module rgb_to_hsv_pixel_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire logic [rgbhsv_pkg::HUE_W-1:0]  hue_deg,
	input wire logic [rgbhsv_pkg::PCT_W-1:0]  sat_pct,
	input wire logic [rgbhsv_pkg::PCT_W-1:0]  val_pct
);

	import rgbhsv_pkg::*;

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> hue_deg <= HUE_W'(HUE_MAX))
		else $error("hue out of range");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sat_pct <= PCT_W'(PCT_SCALE)) && (val_pct <= PCT_W'(PCT_SCALE)))
		else $error("percent out of range");

	a_beat_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("beat without result");

	a_done_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without beat");

endmodule

bind rgb_to_hsv_pixel rgb_to_hsv_pixel_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.hue_deg(hue_deg),
	.sat_pct(sat_pct),
	.val_pct(val_pct)
);

`default_nettype wire

### sim/rgb_to_hsv_pixel_test.sv
`default_nettype none

module rgb_to_hsv_pixel_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbhsv_pkg::*;

	localparam int CH_FULL    = 255;
	localparam int IDLE_LIMIT = 2000;
	localparam int NUM_RANDOM = 1730;

	typedef struct {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] val;
	} hsv_t;

	class hsv_scoreboard;
		hsv_t expected_hsv[$];
		int   failures;

		function hsv_t convert(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
			int ri;
			int gi;
			int bi;
			int hi;
			int lo;
			int span;
			int hue;
			hsv_t res;
			ri = r;
			gi = g;
			bi = b;
			hi = (ri > gi) ? ri : gi;
			hi = (hi > bi) ? hi : bi;
			lo = (ri < gi) ? ri : gi;
			lo = (lo < bi) ? lo : bi;
			span = hi - lo;
			hue = 0;
			if (span != 0) begin
				// blue wins ties over green, green over red
				if (bi == hi) begin
					hue = BASE_BLUE + ((ri - gi) * DEG_SPAN) / span;
				end else if (gi == hi) begin
					hue = BASE_GREEN + ((bi - ri) * DEG_SPAN) / span;
				end else begin
					hue = ((gi - bi) * DEG_SPAN) / span;
				end
				if (hue < 0) begin
					hue += HUE_WRAP;
				end
			end
			res.hue = hue[HUE_W-1:0];
			res.sat = (hi != 0) ? PCT_W'((span * PCT_SCALE) / hi) : '0;
			res.val = PCT_W'((hi * PCT_SCALE) / CH_FULL);
			return res;
		endfunction

		function void note_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
			expected_hsv.push_back(convert(r, g, b));
		endfunction

		function void check_result(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
				logic [PCT_W-1:0] val);
			hsv_t exp_hsv;
			if (expected_hsv.size() == 0) begin
				$display("%0t: unexpected result hue_deg %0d sat_pct %0d val_pct %0d",
					$time, hue, sat, val);
				failures++;
				return;
			end
			exp_hsv = expected_hsv.pop_front();
			if (hue !== exp_hsv.hue) begin
				$display("%0t: hue_deg expected %0d actual %0d", $time, exp_hsv.hue, hue);
				failures++;
			end
			if (sat !== exp_hsv.sat) begin
				$display("%0t: sat_pct expected %0d actual %0d", $time, exp_hsv.sat, sat);
				failures++;
			end
			if (val !== exp_hsv.val) begin
				$display("%0t: val_pct expected %0d actual %0d", $time, exp_hsv.val, val);
				failures++;
			end
		endfunction

		function int pending();
			return expected_hsv.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic [CH_W-1:0]  red;
	logic [CH_W-1:0]  green;
	logic [CH_W-1:0]  blue;
	logic             busy;
	logic             done;
	logic [HUE_W-1:0] hue_deg;
	logic [PCT_W-1:0] sat_pct;
	logic [PCT_W-1:0] val_pct;

	hsv_scoreboard pixel_sb;
	int            idle_cycles = 0;

	rgb_to_hsv_pixel DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.busy    (busy),
		.done    (done),
		.hue_deg (hue_deg),
		.sat_pct (sat_pct),
		.val_pct (val_pct)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				pixel_sb.note_pixel(red, green, blue);
			end
			if (done) begin
				pixel_sb.check_result(hue_deg, sat_pct, val_pct);
			end
			if ((start && !busy) || done) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: watchdog expired, %0d results outstanding", $time,
					pixel_sb.pending());
				$display("rgb_to_hsv_pixel_test: FAIL");
				$finish;
			end
		end
	end

	function int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic send_pixel(int r, int g, int b, int gap);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		red   <= r[CH_W-1:0];
		green <= g[CH_W-1:0];
		blue  <= b[CH_W-1:0];
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pixel_sb.pending() != 0) @(posedge clk);
	endtask

	task automatic send_random_pixel(int gap);
		int mode;
		int base;
		int r;
		int g;
		int b;
		mode = $urandom_range(0, 9);
		r = $urandom_range(0, CH_FULL);
		g = $urandom_range(0, CH_FULL);
		b = $urandom_range(0, CH_FULL);
		case (mode)
			4: begin
				// gray
				g = r;
				b = r;
			end
			5: begin
				// two channels tie for the maximum
				base = $urandom_range(1, CH_FULL);
				case ($urandom_range(0, 2))
					0: begin r = base; g = base; b = $urandom_range(0, base - 1); end
					1: begin g = base; b = base; r = $urandom_range(0, base - 1); end
					default: begin r = base; b = base; g = $urandom_range(0, base - 1); end
				endcase
			end
			6: begin
				// narrow span
				base = $urandom_range(0, CH_FULL - 3);
				r = base + $urandom_range(0, 3);
				g = base + $urandom_range(0, 3);
				b = base + $urandom_range(0, 3);
			end
			7: begin
				// channels pinned to the rails
				if ($urandom_range(0, 1)) r = $urandom_range(0, 1) * CH_FULL;
				if ($urandom_range(0, 1)) g = $urandom_range(0, 1) * CH_FULL;
				if ($urandom_range(0, 1)) b = $urandom_range(0, 1) * CH_FULL;
			end
			default: ;
		endcase
		send_pixel(r, g, b, gap);
	endtask

	initial begin
		int gap;
		pixel_sb    = new;
		arst_n      = 1'b0;
		start       = 1'b0;
		red         = '0;
		green       = '0;
		blue        = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed corners
		send_pixel(0, 0, 0, 0);
		send_pixel(255, 255, 255, 0);
		send_pixel(128, 128, 128, 1);
		send_pixel(255, 0, 0, 0);
		send_pixel(0, 255, 0, 0);
		send_pixel(0, 0, 255, 2);
		send_pixel(255, 255, 0, 0);
		send_pixel(0, 255, 255, 0);
		send_pixel(255, 0, 255, 0);
		send_pixel(255, 0, 1, 3);
		send_pixel(255, 0, 254, 0);
		send_pixel(1, 0, 0, 0);
		send_pixel(0, 0, 1, 0);
		send_pixel(1, 1, 0, 0);
		send_pixel(0, 1, 1, 0);
		send_pixel(255, 254, 254, 0);
		send_pixel(254, 255, 255, 0);
		send_pixel(10, 20, 30, 0);
		send_pixel(200, 100, 50, 0);
		send_pixel(128, 0, 128, 0);
		send_pixel(255, 128, 0, 0);
		send_pixel(85, 170, 255, 0);
		drain();

		for (int i = 0; i < NUM_RANDOM; i++) begin
			gap = (i % 200 < 40) ? 0 : pick_gap();
			send_random_pixel(gap);
			if (i == NUM_RANDOM / 2) begin
				drain();
			end
		end
		@(negedge clk);
		start <= 1'b0;

		while (pixel_sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (pixel_sb.failures == 0) begin
			$display("rgb_to_hsv_pixel_test: PASS");
		end else begin
			$display("rgb_to_hsv_pixel_test: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
